FILE: sv/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Register map, widths and the configuration bundle of the byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int unsigned APB_ADDR_W   = 6;
    localparam int unsigned APB_DATA_W   = 64;
    localparam int unsigned PAT_WORDS    = 4;
    localparam int unsigned PAT_WORD_W   = 64;
    localparam int unsigned CARE_W       = 32;
    localparam int unsigned LEN_W        = 6;
    localparam int unsigned OFFSET_W     = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

    // Register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_PAT_0_7   = 3'd0,
        REG_PAT_8_15  = 3'd1,
        REG_PAT_16_23 = 3'd2,
        REG_PAT_24_31 = 3'd3,
        REG_CARE_MASK = 3'd4,
        REG_PAT_LEN   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [PAT_WORDS-1:0][PAT_WORD_W-1:0] pattern;
        logic [CARE_W-1:0]                    care;
        logic [LEN_W-1:0]                     length;
    } t_cfg;

endpackage

FILE: sv/wbps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: flags that pattern bytes 0..k match ending at the
// newest byte, built from the left neighbor's flag of the previous byte.
// ----------------------------------------------------------------------------
module wbps_cell import wbps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_clear,
    input  logic       i_advance,
    input  logic [7:0] i_data,
    input  logic       i_readable,
    input  logic       i_prev_match,
    input  logic [7:0] i_pat_byte,
    input  logic       i_care,
    output logic       o_match_next,
    output logic       o_match
);

    logic r_match;
    logic n_match;

    assign o_match_next = i_prev_match & i_readable & (~i_care | (i_data == i_pat_byte));
    assign o_match      = r_match;

    always_comb begin
        n_match = r_match;
        if (i_clear) begin
            n_match = 1'b0;
        end else if (i_advance) begin
            n_match = o_match_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

endmodule

FILE: sv/wbps_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// APB register file: four pattern words, care mask and pattern length.
// ----------------------------------------------------------------------------
module wbps_cfg_regs import wbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[5:3]);
    assign w_write = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            case (w_idx)
                REG_PAT_0_7:   n_cfg.pattern[0] = pwdata;
                REG_PAT_8_15:  n_cfg.pattern[1] = pwdata;
                REG_PAT_16_23: n_cfg.pattern[2] = pwdata;
                REG_PAT_24_31: n_cfg.pattern[3] = pwdata;
                REG_CARE_MASK: n_cfg.care       = pwdata[CARE_W-1:0];
                REG_PAT_LEN:   n_cfg.length     = pwdata[LEN_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PAT_0_7:   prdata = r_cfg.pattern[0];
            REG_PAT_8_15:  prdata = r_cfg.pattern[1];
            REG_PAT_16_23: prdata = r_cfg.pattern[2];
            REG_PAT_24_31: prdata = r_cfg.pattern[3];
            REG_CARE_MASK: prdata = APB_DATA_W'(r_cfg.care);
            REG_PAT_LEN:   prdata = APB_DATA_W'(r_cfg.length);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.care    <= '0;
            r_cfg.length  <= LEN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: sv/wildcard_byte_pattern_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_top
// Streaming masked byte signature search over one section at a time.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle and reports the first place in the section
// where the pattern (up to MAX_PATTERN bytes, each either compared or a
// wildcard per care_mask) matches a run of readable bytes. The search is a
// row of MAX_PATTERN cells; cell k holds "pattern bytes 0..k match, ending at
// the newest byte", and each transfer every cell compares the incoming byte
// with its own pattern byte in parallel and takes its left neighbor's flag.
// The match is decided in the transfer's cycle and registered into the result
// register, so a byte can be accepted every cycle with no bubbles. The input
// stalls only while a finished result sits in the output register and the
// consumer stalls it. A match yields found = 1 with the offset of the first
// matched byte; bytes after a match are swallowed until last_byte. A section
// that ends without a match yields found = 0, offset 0. The state is cleared
// directly by the last byte's transfer, with no clearing pass.
// Pattern registers sit at byte address 8*i on the 64-bit APB port; write
// them only between sections.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_top import wbps_pkg::*; #(
    parameter int unsigned MAX_PATTERN   = 32,
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // byte stream
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_readable,
    input  logic                  i_last_byte,
    // result
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_found,
    output logic [OFFSET_W-1:0]   o_match_offset
);

    localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    t_cfg w_cfg;

    wbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Active length minus one: zero acts as one, too long clips to the cell count.
    logic [IDX_W-1:0] w_len_idx;

    always_comb begin
        if (w_cfg.length == '0) begin
            w_len_idx = '0;
        end else if (w_cfg.length > MAX_LEN) begin
            w_len_idx = IDX_W'(MAX_PATTERN - 1);
        end else begin
            w_len_idx = IDX_W'(w_cfg.length - LEN_W'(1));
        end
    end

    // Handshake and per-transfer control
    logic r_out_valid;
    logic r_found;
    logic [OFFSET_W-1:0] r_offset;
    logic r_reported;
    logic [POSITION_BITS-1:0] r_pos;

    logic w_fire;
    logic w_proc;
    logic w_clear;
    logic w_hit;

    logic [MAX_PATTERN-1:0] w_match_next;
    logic [MAX_PATTERN-1:0] w_match;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_fire     = i_in_valid & ~o_in_stall;
    // Bytes after a match are not scanned; only their last_byte matters.
    assign w_proc     = w_fire & ~r_reported;
    assign w_clear    = w_fire & i_last_byte;
    assign w_hit      = w_proc & w_match_next[w_len_idx];

    // Row of compare cells: cell 0 starts a fresh partial match on every scanned byte.
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic w_prev;

        if (k == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_match[k-1];
        end

        wbps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_clear      (w_clear),
            .i_advance    (w_proc),
            .i_data       (i_data_byte),
            .i_readable   (i_readable),
            .i_prev_match (w_prev),
            .i_pat_byte   (w_cfg.pattern[k/8][8*(k%8) +: 8]),
            .i_care       (w_cfg.care[k]),
            .o_match_next (w_match_next[k]),
            .o_match      (w_match[k])
        );
    end

    // Offset of the first matched byte, wrapped to the position width.
    logic [POSITION_BITS-1:0] w_start;
    assign w_start = r_pos - POSITION_BITS'(w_len_idx);

    logic                     n_out_valid;
    logic                     n_found;
    logic [OFFSET_W-1:0]      n_offset;
    logic                     n_reported;
    logic [POSITION_BITS-1:0] n_pos;

    always_comb begin
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_offset    = r_offset;
        n_reported  = r_reported;
        n_pos       = r_pos;

        // drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (w_proc) begin
            n_pos = r_pos + POSITION_BITS'(1);
        end

        if (w_hit) begin
            n_out_valid = 1'b1;
            n_found     = 1'b1;
            n_offset    = OFFSET_W'(w_start);
            n_reported  = 1'b1;
        end else if (w_proc && i_last_byte) begin
            n_out_valid = 1'b1;
            n_found     = 1'b0;
            n_offset    = '0;
        end

        // section ends: rewind for the next one
        if (w_clear) begin
            n_pos      = '0;
            n_reported = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_reported  <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_reported  <= n_reported;
            r_pos       <= n_pos;
        end
    end

    // hold result payload without reset
    always_ff @(posedge i_clk) begin
        r_found  <= n_found;
        r_offset <= n_offset;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

endmodule

FILE: sv/wbps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks of the byte pattern scanner, bound to the top level.
// ----------------------------------------------------------------------------
module wbps_checker import wbps_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_found,
    input logic [OFFSET_W-1:0] o_match_offset
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_found) && $stable(o_match_offset)))
        else $error("stalled result changed");

    // never stall the input while the output register is free
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_offset == '0))
        else $error("not-found result carries an offset");

    // a result appears only after an input transfer
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("result without input transfer");

    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !(i_in_valid && !o_in_stall)) |=> !o_out_valid)
        else $error("result repeated after transfer");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_found        (o_found),
    .o_match_offset (o_match_offset)
);
